FILE: sv/ping_latency_health_stats_core_defines.svh
// Assertion macros for the checker file of the latency statistics core.
`ifndef PING_LATENCY_HEALTH_STATS_CORE_DEFINES_SVH
`define PING_LATENCY_HEALTH_STATS_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define PLHS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define PLHS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/plhs_pkg.sv
// Types and constants shared by the latency statistics core.
`timescale 1ns / 1ps
`default_nettype none
package plhs_pkg;

   localparam int OP_W    = 2;
   localparam int SEQ_W   = 16;
   localparam int IDENT_W = 16;
   localparam int SEC_W   = 32;
   localparam int USEC_W  = 20;
   localparam int CNT_W   = 9;
   localparam int SUM_W   = 32;
   localparam int EPOCH_W = 8;

   localparam int REQ_DATA_W = 88;   // 84 field bits, padded to bytes
   localparam int RSP_DATA_W = 120;  // 114 field bits, padded to bytes

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [OP_W-1:0] OP_SEND   = 2'd0;
   localparam logic [OP_W-1:0] OP_REPLY  = 2'd1;
   localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_IDENT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PACKET_COUNT   = 1'd1;

   localparam logic [IDENT_W-1:0] EXPECTED_IDENT_RST = 16'd0;
   localparam logic [CNT_W-1:0]   PACKET_COUNT_RST   = 9'd1;

   // epoch 0 marks a cleared slot
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'hff;

   localparam logic [SUM_W-1:0] USEC_PER_SEC = 32'd1000000;
   // x / 1000 == (x * MS_MAGIC) >> MS_SHIFT for every 32-bit x
   localparam int               MAGIC_W  = 29;
   localparam logic [MAGIC_W-1:0] MS_MAGIC = 29'd274877907;
   localparam int               MS_SHIFT = 38;
   localparam int               PROD_W   = SUM_W + MAGIC_W;

   localparam logic [SUM_W-1:0] MEAN_WEIGHT = 32'd25;
   localparam logic [SUM_W-1:0] LOST_WEIGHT = 32'd3000;

   typedef struct packed {
      logic [EPOCH_W-1:0] epoch;
      logic [USEC_W-1:0]  usec;
      logic [SEC_W-1:0]   sec;
   } slot_entry_type;

   typedef struct packed {
      logic              start;
      logic [SEC_W-1:0]  now_sec;
      logic [USEC_W-1:0] now_usec;
      logic [SEC_W-1:0]  then_sec;
      logic [USEC_W-1:0] then_usec;
   } delay_req_type;

   typedef struct packed {
      logic             valid;
      logic [SUM_W-1:0] ms;
   } delay_rsp_type;

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] dividend;
      logic [CNT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

FILE: sv/plhs_slot_mem.sv
// Send-time memory: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none
module plhs_slot_mem #(
   parameter int SLOT_COUNT = 256,
   localparam int ADDR_W = $clog2(SLOT_COUNT)
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  plhs_pkg::slot_entry_type wr_data,
   input  logic                     rd_en,
   input  logic [ADDR_W-1:0]        rd_addr,
   output plhs_pkg::slot_entry_type rd_data
);
   import plhs_pkg::*;

   slot_entry_type slot_mem [SLOT_COUNT];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: sv/plhs_delay.sv
// Round-trip delay in milliseconds, two registered multiply stages.
`timescale 1ns / 1ps
`default_nettype none
module plhs_delay (
   input  logic                    clock,
   input  logic                    reset,
   input  plhs_pkg::delay_req_type req,
   output plhs_pkg::delay_rsp_type rsp
);
   import plhs_pkg::*;

   logic [SUM_W-1:0]  scaled_ff, scaled_in;
   logic [SUM_W-1:0]  dusec_ff, dusec_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              v1_ff, v1_in;
   logic              v2_ff, v2_in;
   logic [SUM_W-1:0]  dsec;
   logic [SUM_W-1:0]  total_us;

   always_comb begin
      dsec      = req.now_sec - req.then_sec;
      dusec_in  = SUM_W'(req.now_usec) - SUM_W'(req.then_usec);
      // low 32 bits only: the microsecond count wraps
      scaled_in = SUM_W'(dsec * USEC_PER_SEC);
      v1_in     = req.start;
      total_us  = scaled_ff + dusec_ff;
      prod_in   = PROD_W'(total_us) * PROD_W'(MS_MAGIC);
      v2_in     = v1_ff;
   end

   always_ff @(posedge clock) begin
      scaled_ff <= scaled_in;
      dusec_ff  <= dusec_in;
      prod_ff   <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   assign rsp.valid = v2_ff;
   assign rsp.ms    = SUM_W'(prod_ff[PROD_W-1:MS_SHIFT]);

endmodule
`default_nettype wire

FILE: sv/plhs_div.sv
// Restoring divider, one quotient bit per cycle, for the mean delay.
`timescale 1ns / 1ps
`default_nettype none
module plhs_div (
   input  logic                  clock,
   input  logic                  reset,
   input  plhs_pkg::div_req_type req,
   output plhs_pkg::div_rsp_type rsp
);
   import plhs_pkg::*;

   localparam int STEP_W = $clog2(SUM_W);

   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  divisor_ff, divisor_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W:0]    trial;
   logic              fits;

   always_comb begin
      trial      = {rem_ff, quo_ff[SUM_W-1]};
      fits       = trial >= {1'b0, divisor_ff};
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      step_in    = step_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (req.start) begin
         rem_in     = '0;
         quo_in     = req.dividend;
         divisor_in = req.divisor;
         step_in    = STEP_W'(SUM_W - 1);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? CNT_W'(trial - {1'b0, divisor_ff}) : CNT_W'(trial);
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
      step_ff    <= step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule
`default_nettype wire

FILE: sv/ping_latency_health_stats_core.sv
// Echo round-trip statistics: slot memory, delay pipeline, divider and control.
//
//   channel  dir  handshake            payload
//   req      in   req_tvalid/tready    tuser: op; tdata: seq, ident, time_sec, time_usec
//   rsp      out  rsp_tvalid/tready    tdata: received, lost, delay_total, mean, health
//   csr      in   csr_we               csr_index, csr_wdata
//
// Send: accept, slot reduction, memory write. Reply: the same steps, plus a memory read
// when counted, plus the two-stage delay pipeline when counted with a valid slot. Finish:
// the 32-step divider, skipped when nothing was received, then the report step.
// After reset, and after every 255th finish, a clearing pass writes every slot with req_tready
// low. A waiting result does not block input; a finish waits in its report step until the
// output register is free.
`timescale 1ns / 1ps
`default_nettype none
module ping_latency_health_stats_core #(
   parameter int SLOT_COUNT = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [15:0] seq, [31:16] ident, [63:32] time_sec, [83:64] time_usec
   input  logic [plhs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] op
   input  logic [plhs_pkg::OP_W-1:0]         req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [8:0] received, [17:9] lost, [49:18] delay_total, [81:50] delay_mean,
   // [113:82] health_score
   output logic [plhs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_we,
   input  logic [plhs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [plhs_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import plhs_pkg::*;

   localparam int ADDR_W = $clog2(SLOT_COUNT);
   localparam logic [SUM_W-1:0] SLOT_RECIP = SUM_W'((64'd1 << 32) / SLOT_COUNT);

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_CLEAR  = 3'd0;
   localparam logic [ST_W-1:0] ST_IDLE   = 3'd1;
   localparam logic [ST_W-1:0] ST_SLOT   = 3'd2;
   localparam logic [ST_W-1:0] ST_ACCESS = 3'd3;
   localparam logic [ST_W-1:0] ST_READ   = 3'd4;
   localparam logic [ST_W-1:0] ST_DELAY  = 3'd5;
   localparam logic [ST_W-1:0] ST_DIV    = 3'd6;
   localparam logic [ST_W-1:0] ST_REPORT = 3'd7;

   logic [ST_W-1:0]       state_ff, state_in;
   logic [ADDR_W-1:0]     sweep_ff, sweep_in;
   logic [EPOCH_W-1:0]    epoch_ff, epoch_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [SUM_W-1:0]      accum_ff, accum_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IDENT_W-1:0]    expected_ff, expected_in;
   logic [CNT_W-1:0]      packets_ff, packets_in;

   logic [OP_W-1:0]       op_ff, op_in;
   logic [SEQ_W-1:0]      seq_ff, seq_in;
   logic [IDENT_W-1:0]    ident_ff, ident_in;
   logic [SEC_W-1:0]      tsec_ff, tsec_in;
   logic [USEC_W-1:0]     tusec_ff, tusec_in;
   logic [SEQ_W-1:0]      quot_ff, quot_in;
   logic [SUM_W-1:0]      mean_ff, mean_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [SEQ_W+SUM_W-1:0] quot_prod;
   logic [SUM_W:0]         quot_back;
   logic [SEQ_W:0]         slot_rem;
   logic [SEQ_W:0]         slot_full;
   logic [ADDR_W-1:0]      slot;
   logic [CNT_W-1:0]       lost;
   logic [SUM_W-1:0]       health;

   logic                   mem_wr_en;
   logic [ADDR_W-1:0]      mem_wr_addr;
   slot_entry_type         mem_wr_data;
   logic                   mem_rd_en;
   slot_entry_type         mem_rd_data;
   delay_req_type          delay_req;
   delay_rsp_type          delay_rsp;
   div_req_type            div_req;
   div_rsp_type            div_rsp;

   plhs_slot_mem #(.SLOT_COUNT(SLOT_COUNT)) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (slot),
      .rd_data (mem_rd_data)
   );

   plhs_delay u_delay (
      .clock (clock),
      .reset (reset),
      .req   (delay_req),
      .rsp   (delay_rsp)
   );

   plhs_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // seq mod SLOT_COUNT: reciprocal estimate is low by at most one
   always_comb begin
      quot_prod = (SEQ_W+SUM_W)'(seq_in) * (SEQ_W+SUM_W)'(SLOT_RECIP);
      quot_back = (SUM_W+1)'(quot_ff) * (SUM_W+1)'(SLOT_COUNT);
      slot_rem  = (SEQ_W+1)'((SUM_W+1)'(seq_ff) - quot_back);
      slot_full = (slot_rem >= (SEQ_W+1)'(SLOT_COUNT)) ?
                  slot_rem - (SEQ_W+1)'(SLOT_COUNT) : slot_rem;
      slot      = slot_full[ADDR_W-1:0];
   end

   always_comb begin
      lost   = (packets_ff > count_ff) ? packets_ff - count_ff : '0;
      health = (count_ff == '0) ? '1 :
               SUM_W'(mean_ff * MEAN_WEIGHT) + SUM_W'(SUM_W'(lost) * LOST_WEIGHT);
   end

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      epoch_in     = epoch_ff;
      count_in     = count_ff;
      accum_in     = accum_ff;
      rsp_valid_in = rsp_valid_ff;
      expected_in  = expected_ff;
      packets_in   = packets_ff;
      op_in        = op_ff;
      seq_in       = seq_ff;
      ident_in     = ident_ff;
      tsec_in      = tsec_ff;
      tusec_in     = tusec_ff;
      quot_in      = quot_ff;
      mean_in      = mean_ff;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = slot;
      mem_wr_data  = '{epoch: epoch_ff, usec: tusec_ff, sec: tsec_ff};
      mem_rd_en    = 1'b0;
      delay_req    = '{start: 1'b0, now_sec: tsec_ff, now_usec: tusec_ff,
                       then_sec: mem_rd_data.sec, then_usec: mem_rd_data.usec};
      div_req      = '{start: 1'b0, dividend: accum_ff, divisor: count_ff};

      if (csr_we) begin
         case (csr_index)
            CSR_EXPECTED_IDENT: expected_in = csr_wdata[IDENT_W-1:0];
            CSR_PACKET_COUNT:   packets_in  = csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = sweep_ff;
            mem_wr_data = '0;
            sweep_in    = sweep_ff + ADDR_W'(1);
            if (sweep_ff == ADDR_W'(SLOT_COUNT - 1)) begin
               epoch_in = EPOCH_FIRST;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in    = req_tuser;
               seq_in   = req_tdata[15:0];
               ident_in = req_tdata[31:16];
               tsec_in  = req_tdata[63:32];
               tusec_in = req_tdata[83:64];
               case (req_tuser)
                  OP_SEND, OP_REPLY: begin
                     state_in = ST_SLOT;
                  end
                  OP_FINISH: begin
                     if (count_ff == '0) begin
                        mean_in  = '1;
                        state_in = ST_REPORT;
                     end else begin
                        div_req.start = 1'b1;
                        state_in      = ST_DIV;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SLOT: begin
            quot_in  = quot_prod[SEQ_W+SUM_W-1:SUM_W];
            state_in = ST_ACCESS;
         end
         ST_ACCESS: begin
            state_in = ST_IDLE;
            if (op_ff == OP_SEND) begin
               mem_wr_en = 1'b1;
            end else if (ident_ff == expected_ff && count_ff < packets_ff) begin
               count_in  = count_ff + CNT_W'(1);
               mem_rd_en = 1'b1;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            // slot counts as sent only if written in the current round
            if (mem_rd_data.epoch == epoch_ff) begin
               delay_req.start = 1'b1;
               state_in        = ST_DELAY;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DELAY: begin
            if (delay_rsp.valid) begin
               accum_in = accum_ff + delay_rsp.ms;
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               mean_in  = div_rsp.quotient;
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({health, mean_ff, accum_ff, lost, count_ff});
               count_in     = '0;
               accum_in     = '0;
               if (epoch_ff == EPOCH_LAST) begin
                  sweep_in = '0;
                  state_in = ST_CLEAR;
               end else begin
                  epoch_in = epoch_ff + EPOCH_W'(1);
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         epoch_ff     <= EPOCH_FIRST;
         count_ff     <= '0;
         accum_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         expected_ff  <= EXPECTED_IDENT_RST;
         packets_ff   <= PACKET_COUNT_RST;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         epoch_ff     <= epoch_in;
         count_ff     <= count_in;
         accum_ff     <= accum_in;
         rsp_valid_ff <= rsp_valid_in;
         expected_ff  <= expected_in;
         packets_ff   <= packets_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      seq_ff      <= seq_in;
      ident_ff    <= ident_in;
      tsec_ff     <= tsec_in;
      tusec_ff    <= tusec_in;
      quot_ff     <= quot_in;
      mean_ff     <= mean_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

FILE: sv/plhs_checker.sv
// Port-level checks for the latency statistics core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "ping_latency_health_stats_core_defines.svh"
module plhs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [plhs_pkg::OP_W-1:0]       req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [plhs_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import plhs_pkg::*;

   `PLHS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "result beat changed while stalled")

   `PLHS_ASSERT_IMP(a_none_all_ones, clock, reset, rsp_tvalid && rsp_tdata[8:0] == '0,
      rsp_tdata[81:50] == '1 && rsp_tdata[113:82] == '1, "empty round not all ones")

   `PLHS_ASSERT_IMP(a_mean_bound, clock, reset, rsp_tvalid && rsp_tdata[8:0] != '0,
      rsp_tdata[81:50] <= rsp_tdata[49:18], "mean exceeds delay total")

   `PLHS_ASSERT_NXT(a_no_spurious, clock, reset,
      req_tvalid && req_tready && req_tuser != OP_FINISH && !rsp_tvalid,
      !rsp_tvalid, "result without finish")

endmodule

bind ping_latency_health_stats_core plhs_checker u_plhs_checker (.*);
`default_nettype wire
